@@ rtl/core/timed_cooling_schedule_controller_macros.svh @@
// Assertion macros for the cooling schedule controller.
// Every macro samples at the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef TIMED_COOLING_SCHEDULE_CONTROLLER_MACROS_SVH
`define TIMED_COOLING_SCHEDULE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define TCSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TCSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCSC_ASSERT_SAME(label, ante, cons)
`define TCSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/tcsc_pkg.sv @@
`timescale 1ns / 1ps
package tcsc_pkg;

    localparam int unsigned TIME_W = 17;
    localparam int unsigned HEAT_W = 12;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned FAN_W  = 3;

    localparam logic [TIME_W-1:0] SEC_PER_HOUR = TIME_W'(3600);
    localparam logic [TIME_W-1:0] SEC_PER_MIN  = TIME_W'(60);
    localparam logic [HOUR_W-1:0] HOUR_MIDNIGHT = HOUR_W'(24);
    localparam logic [HOUR_W-1:0] HOUR_NOON_END = HOUR_W'(11);
    localparam logic [HOUR_W-1:0] HOUR_EVE_END  = HOUR_W'(20);

    localparam logic [TIME_W-1:0]        MAX_RUN_RST      = TIME_W'(10800);
    localparam logic [TIME_W-1:0]        RESTART_HOLD_RST = TIME_W'(7200);
    localparam logic [TIME_W-1:0]        ADJUST_HOLD_RST  = TIME_W'(1200);
    localparam logic signed [HEAT_W-1:0] HOT_THR_RST      = HEAT_W'(560);
    localparam logic signed [HEAT_W-1:0] COLD_THR_RST     = HEAT_W'(416);

    localparam logic [FAN_W-1:0] FAN_NONE = FAN_W'(0);
    localparam logic [FAN_W-1:0] FAN_LOW  = FAN_W'(2);
    localparam logic [FAN_W-1:0] FAN_MID  = FAN_W'(3);
    localparam logic [FAN_W-1:0] FAN_HIGH = FAN_W'(4);

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_FAN  = 2'd0,
        MODE_COOL = 2'd1,
        MODE_DRY  = 2'd2
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_RUN      = 3'd0,
        REG_RESTART_HOLD = 3'd1,
        REG_ADJUST_HOLD  = 3'd2,
        REG_HOT_THR      = 3'd3,
        REG_COLD_THR     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0]        max_run;
        logic [TIME_W-1:0]        restart_hold;
        logic [TIME_W-1:0]        adjust_hold;
        logic signed [HEAT_W-1:0] hot_thr;
        logic signed [HEAT_W-1:0] cold_thr;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]        now;
        logic                     afternoon;
        logic                     evening;
        logic                     morning;
        logic signed [HEAT_W-1:0] heat;
    } t_tick;

    // True when now - stamp, taken as signed, exceeds the hold.
    function automatic logic hold_over(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] stamp,
                                       input logic [TIME_W-1:0] hold);
        logic signed [TIME_W+1:0] diff;
        diff = $signed({2'b00, now}) - $signed({2'b00, stamp});
        return diff > $signed({2'b00, hold});
    endfunction

endpackage

@@ rtl/core/tcsc_time.sv @@
`timescale 1ns / 1ps
module tcsc_time import tcsc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [HOUR_W-1:0]        i_hour,
    input  logic [MIN_W-1:0]         i_minute,
    input  logic [SEC_W-1:0]         i_second,
    input  logic signed [HEAT_W-1:0] i_heat_index,
    input  logic                     i_take,
    output logic                     o_tick_valid,
    output t_tick                    o_tick
);

    logic              r_valid;
    t_tick             r_tick;
    t_tick             n_tick;
    logic [HOUR_W-1:0] hour_eff;

    assign o_ready = !r_valid || i_take;

    // Midnight counts as hour 24.
    always_comb begin
        hour_eff = (i_hour == '0) ? HOUR_MIDNIGHT : i_hour;
        n_tick.now = TIME_W'(hour_eff) * SEC_PER_HOUR
                   + TIME_W'(i_minute) * SEC_PER_MIN
                   + TIME_W'(i_second);
        n_tick.afternoon = (hour_eff > HOUR_NOON_END) && (hour_eff <= HOUR_EVE_END);
        n_tick.evening   = hour_eff > HOUR_EVE_END;
        n_tick.morning   = hour_eff <= HOUR_NOON_END;
        n_tick.heat      = i_heat_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tick <= n_tick;
        end
    end

    assign o_tick_valid = r_valid;
    assign o_tick       = r_tick;

endmodule

@@ rtl/core/tcsc_core.sv @@
`timescale 1ns / 1ps
module tcsc_core import tcsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_tick_valid,
    input  t_tick            i_tick,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_ready,
    output t_cmd             o_command_kind,
    output t_mode            o_ac_mode,
    output logic [FAN_W-1:0] o_fan_level,
    output logic             o_ac_is_on
);

    logic              r_ac_on, n_ac_on;
    logic              r_lock, n_lock;
    logic [TIME_W-1:0] r_on_stamp, n_on_stamp;
    logic [TIME_W-1:0] r_off_stamp, n_off_stamp;
    logic [TIME_W-1:0] r_adj_stamp, n_adj_stamp;
    logic              r_out_valid;
    t_cmd              r_cmd, n_cmd;
    t_mode             r_mode, n_mode;
    logic [FAN_W-1:0]  r_fan, n_fan;
    logic              lock_cur;

    assign o_take = i_tick_valid && (!r_out_valid || i_ready);

    always_comb begin
        lock_cur = r_lock && !hold_over(i_tick.now, r_off_stamp, i_cfg.restart_hold);
        n_ac_on     = r_ac_on;
        n_lock      = lock_cur;
        n_on_stamp  = r_on_stamp;
        n_off_stamp = r_off_stamp;
        n_adj_stamp = r_adj_stamp;
        n_cmd       = CMD_NONE;
        n_mode      = MODE_FAN;
        n_fan       = FAN_NONE;
        priority if (!r_ac_on && !lock_cur && i_tick.afternoon
                     && (i_tick.heat > i_cfg.hot_thr)) begin
            n_cmd      = CMD_ON;
            n_mode     = MODE_COOL;
            n_fan      = FAN_HIGH;
            n_ac_on    = 1'b1;
            n_on_stamp = i_tick.now;
        end else if (i_tick.evening && !r_ac_on) begin
            n_cmd   = CMD_ON;
            n_mode  = MODE_COOL;
            n_fan   = FAN_LOW;
            n_ac_on = 1'b1;
        end else if (i_tick.evening && r_ac_on && (i_tick.heat < i_cfg.cold_thr)
                     && hold_over(i_tick.now, r_adj_stamp, i_cfg.adjust_hold)) begin
            n_cmd       = CMD_ON;
            n_mode      = MODE_DRY;
            n_fan       = FAN_MID;
            n_adj_stamp = i_tick.now;
        end else if (r_ac_on && i_tick.afternoon
                     && hold_over(i_tick.now, r_on_stamp, i_cfg.max_run)) begin
            n_cmd       = CMD_OFF;
            n_ac_on     = 1'b0;
            n_off_stamp = i_tick.now;
            n_lock      = 1'b1;
        end else if (r_ac_on && i_tick.morning) begin
            n_cmd       = CMD_OFF;
            n_ac_on     = 1'b0;
            n_lock      = 1'b1;
            n_on_stamp  = '0;
            n_off_stamp = '0;
            n_adj_stamp = '0;
        end else begin
            n_cmd = CMD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac_on     <= 1'b0;
            r_lock      <= 1'b0;
            r_on_stamp  <= '0;
            r_off_stamp <= '0;
            r_adj_stamp <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_ac_on     <= n_ac_on;
                r_lock      <= n_lock;
                r_on_stamp  <= n_on_stamp;
                r_off_stamp <= n_off_stamp;
                r_adj_stamp <= n_adj_stamp;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd  <= n_cmd;
            r_mode <= n_mode;
            r_fan  <= n_fan;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_kind = r_cmd;
    assign o_ac_mode      = r_mode;
    assign o_fan_level    = r_fan;
    // On-state is only looked at with o_valid; it always matches the last word.
    assign o_ac_is_on     = r_ac_on;

endmodule

@@ rtl/core/timed_cooling_schedule_controller.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// -------   ---------  ------------------  -----------------------------------------
// tick      in         i_valid / o_ready   i_hour, i_minute, i_second, i_heat_index
// command   out        o_valid / i_ready   o_command_kind, o_ac_mode, o_fan_level,
//                                          o_ac_is_on
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One tick per clock while the output is not stalled. A tick taken sits in the time
// stage register; the decision stage runs the priority chain on it and, when it takes
// the tick, loads the command word and the on-state, lockout and stamps, raising o_valid.
// Reset is synchronous, active low: state clears, config registers load defaults.
// A stalled output holds its word; the time stage keeps accepting until it is full.
`include "timed_cooling_schedule_controller_macros.svh"
module timed_cooling_schedule_controller import tcsc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // tick input
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [HOUR_W-1:0]        i_hour,
    input  logic [MIN_W-1:0]         i_minute,
    input  logic [SEC_W-1:0]         i_second,
    input  logic signed [HEAT_W-1:0] i_heat_index,
    // command output
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_command_kind,
    output logic [1:0]               o_ac_mode,
    output logic [FAN_W-1:0]         o_fan_level,
    output logic                     o_ac_is_on,
    // register writes
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [TIME_W-1:0]        i_cfg_data
);

    t_cfg  r_cfg;
    logic  tick_valid;
    t_tick tick;
    logic  take;
    t_cmd  cmd;
    t_mode mode;

    // Configuration registers: to be written only while idle, so no shadowing; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_run      <= MAX_RUN_RST;
            r_cfg.restart_hold <= RESTART_HOLD_RST;
            r_cfg.adjust_hold  <= ADJUST_HOLD_RST;
            r_cfg.hot_thr      <= HOT_THR_RST;
            r_cfg.cold_thr     <= COLD_THR_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_RUN:      r_cfg.max_run      <= i_cfg_data;
                REG_RESTART_HOLD: r_cfg.restart_hold <= i_cfg_data;
                REG_ADJUST_HOLD:  r_cfg.adjust_hold  <= i_cfg_data;
                REG_HOT_THR:      r_cfg.hot_thr      <= $signed(i_cfg_data[HEAT_W-1:0]);
                REG_COLD_THR:     r_cfg.cold_thr     <= $signed(i_cfg_data[HEAT_W-1:0]);
                default:          ; // drop writes to unused indexes
            endcase
        end
    end

    // Stage one: seconds of day and time-of-day bands.
    tcsc_time u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_second     (i_second),
        .i_heat_index (i_heat_index),
        .i_take       (take),
        .o_tick_valid (tick_valid),
        .o_tick       (tick)
    );

    // Stage two: priority chain, schedule state and the output register.
    tcsc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_tick_valid   (tick_valid),
        .i_tick         (tick),
        .o_take         (take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_command_kind (cmd),
        .o_ac_mode      (mode),
        .o_fan_level    (o_fan_level),
        .o_ac_is_on     (o_ac_is_on)
    );

    assign o_command_kind = cmd;
    assign o_ac_mode      = mode;

    // Mode and fan are only nonzero on an on command.
    `TCSC_ASSERT_SAME(a_idle_fields, o_valid && (o_command_kind != CMD_ON), (o_ac_mode == MODE_FAN) && (o_fan_level == FAN_NONE))
    // An off command leaves the cooler off; an on command leaves it on.
    `TCSC_ASSERT_SAME(a_off_state, o_valid && (o_command_kind == CMD_OFF), !o_ac_is_on)
    `TCSC_ASSERT_SAME(a_on_state, o_valid && (o_command_kind == CMD_ON), o_ac_is_on)
    // Back pressure only reaches the input when the time stage holds a tick.
    `TCSC_ASSERT_SAME(a_ready_full, !o_ready, tick_valid && o_valid && !i_ready)
    // A taken tick always shows up as a valid word next cycle.
    `TCSC_ASSERT_NEXT(a_take_out, take, o_valid)

endmodule
